// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sdspi_pkg.sv
// Package with the types, codes and command tables of the SD card SPI sequencer.
`default_nettype none
package sdspi_pkg;

   localparam int BLOCK_BYTES_DEF     = 512;
   localparam int INIT_IDLE_BYTES_DEF = 11;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_XCHG  = 3'd3;
   localparam logic [2:0] OP_WDATA = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_IDLE  = 3'd1;
   localparam logic [2:0] ST_VOLTAGE  = 3'd2;
   localparam logic [2:0] ST_ACMD41   = 3'd3;
   localparam logic [2:0] ST_OCR      = 3'd4;
   localparam logic [2:0] ST_TIMEOUT  = 3'd5;
   localparam logic [2:0] ST_NO_TOKEN = 3'd6;
   localparam logic [2:0] ST_WR_REJ   = 3'd7;

   localparam logic [1:0] REG_RESPONSE_RETRIES = 2'd0;
   localparam logic [1:0] REG_REINIT_AT        = 2'd1;
   localparam logic [1:0] REG_TOKEN_TRIES      = 2'd2;
   localparam logic [1:0] REG_ACMD41_TRIES     = 2'd3;

   localparam logic [7:0] TOKEN_START  = 8'hFE;
   localparam logic [7:0] CMD17_INDEX  = 8'h51;
   localparam logic [7:0] CMD24_INDEX  = 8'h58;
   localparam logic [7:0] R1_IDLE      = 8'h01;
   localparam logic [7:0] R1_READY     = 8'h00;
   localparam logic [4:0] WRESP_MASKED = 5'h05;

   typedef enum logic [4:0] {
      P_IDLE, P_INIT_IDLE, P_CMD0, P_CMD0_R, P_CMD8, P_CMD8_R, P_CMD55, P_CMD55_R,
      P_ACMD41, P_ACMD41_R, P_CMD58, P_CMD58_R, P_CMDRW, P_CMDRW_R, P_TOKEN,
      P_RDATA, P_RCRC, P_WTOKEN, P_WWAIT, P_WDATA, P_WCRC, P_WRESP
   } phase_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] sector;
      logic [7:0]  rx_byte;
      logic [7:0]  wr_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       cs_low;
      logic       need_data;
      logic       rd_valid;
      logic [7:0] rd_byte;
      logic       rd_last;
      logic       done_res;
      logic [2:0] status;
      logic       high_capacity;
   } rsp_type;

   typedef struct packed {
      logic [7:0] response_retries;
      logic [7:0] reinit_at;
      logic [7:0] token_tries;
      logic [7:0] acmd41_tries;
   } cfg_type;

   // Bytes of the fixed init commands: index, four argument bytes, CRC, trailer.
   function automatic logic [7:0] init_cmd_byte(input phase_type ph, input logic [2:0] i);
      logic [2:0] k;
      k = (i < 3'd7) ? i : 3'd6;
      init_cmd_byte = 8'hFF;
      case (ph)
         P_CMD0: begin
            case (k)
               3'd0: init_cmd_byte = 8'h40;
               3'd5: init_cmd_byte = 8'h95;
               3'd6: init_cmd_byte = 8'hFF;
               default: init_cmd_byte = 8'h00;
            endcase
         end
         P_CMD8: begin
            case (k)
               3'd0: init_cmd_byte = 8'h48;
               3'd3: init_cmd_byte = 8'h01;
               3'd4: init_cmd_byte = 8'hAA;
               3'd5: init_cmd_byte = 8'h87;
               3'd6: init_cmd_byte = 8'hFF;
               default: init_cmd_byte = 8'h00;
            endcase
         end
         P_CMD55: begin
            case (k)
               3'd0: init_cmd_byte = 8'h77;
               3'd6: init_cmd_byte = 8'hFF;
               default: init_cmd_byte = 8'h00;
            endcase
         end
         P_ACMD41: begin
            case (k)
               3'd0: init_cmd_byte = 8'h69;
               3'd1: init_cmd_byte = 8'h40;
               3'd6: init_cmd_byte = 8'hFF;
               default: init_cmd_byte = 8'h00;
            endcase
         end
         P_CMD58: begin
            case (k)
               3'd0: init_cmd_byte = 8'h7A;
               3'd5: init_cmd_byte = 8'h75;
               3'd6: init_cmd_byte = 8'hFF;
               default: init_cmd_byte = 8'h00;
            endcase
         end
         default: init_cmd_byte = 8'hFF;
      endcase
   endfunction

   // A zero count register behaves as one.
   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      at_least_one = (v == 8'd0) ? 8'd1 : v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/sdspi_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
`default_nettype none
interface sdspi_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [31:0] sector;
   logic [7:0]  rx_byte;
   logic [7:0]  wr_byte;
   modport source (output valid, opcode, sector, rx_byte, wr_byte, input ready);
   modport sink (input valid, opcode, sector, rx_byte, wr_byte, output ready);
endinterface

interface sdspi_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       cs_low;
   logic       need_data;
   logic       rd_valid;
   logic [7:0] rd_byte;
   logic       rd_last;
   logic       done_res;
   logic [2:0] status;
   logic       high_capacity;
   modport source (output valid, tx_valid, tx_byte, cs_low, need_data, rd_valid, rd_byte,
                   rd_last, done_res, status, high_capacity, input ready);
   modport sink (input valid, tx_valid, tx_byte, cs_low, need_data, rd_valid, rd_byte,
                 rd_last, done_res, status, high_capacity, output ready);
endinterface

interface sdspi_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sd_card_spi_command_sequencer_unit.sv
// An accepted item is held in the input register, and its result is stored in the result register.
// One item per cycle while results are taken; the whole step is one pass of the sequencer logic.
// While a result waits unread, the input register takes one more item and then input stalls.
// Reset is synchronous and active high: idle phase, cleared counters, default registers.
// Top level of the SD card SPI command sequencer.
`default_nettype none
module sd_card_spi_command_sequencer_unit #(
   parameter int BLOCK_BYTES     = sdspi_pkg::BLOCK_BYTES_DEF,
   parameter int INIT_IDLE_BYTES = sdspi_pkg::INIT_IDLE_BYTES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   sdspi_req_if.sink   req_chan,
   sdspi_rsp_if.source rsp_chan,
   sdspi_csr_if.sink   csr_chan
);
   import sdspi_pkg::*;
   `include "assert_macros.svh"

   logic    s1_valid_ff;
   req_type s1_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   cfg_type cfg_ff;
   rsp_type step_result;
   logic    advance;

   // An item moves on when the result register is free or being emptied.
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_item_ff <= '{opcode: req_chan.opcode, sector: req_chan.sector,
                         rx_byte: req_chan.rx_byte, wr_byte: req_chan.wr_byte};
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{response_retries: 8'd10, reinit_at: 8'd5,
                     token_tries: 8'd100, acmd41_tries: 8'd4};
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_RESPONSE_RETRIES: cfg_ff.response_retries <= csr_chan.data;
            REG_REINIT_AT:        cfg_ff.reinit_at        <= csr_chan.data;
            REG_TOKEN_TRIES:      cfg_ff.token_tries      <= csr_chan.data;
            REG_ACMD41_TRIES:     cfg_ff.acmd41_tries     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   sdspi_engine #(
      .BLOCK_BYTES     (BLOCK_BYTES),
      .INIT_IDLE_BYTES (INIT_IDLE_BYTES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_data_ff <= step_result;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tx_valid      = rsp_data_ff.tx_valid;
   assign rsp_chan.tx_byte       = rsp_data_ff.tx_byte;
   assign rsp_chan.cs_low        = rsp_data_ff.cs_low;
   assign rsp_chan.need_data     = rsp_data_ff.need_data;
   assign rsp_chan.rd_valid      = rsp_data_ff.rd_valid;
   assign rsp_chan.rd_byte       = rsp_data_ff.rd_byte;
   assign rsp_chan.rd_last       = rsp_data_ff.rd_last;
   assign rsp_chan.done_res      = rsp_data_ff.done_res;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.high_capacity = rsp_data_ff.high_capacity;

   // A blocked result keeps the pending item in the input register.
   `ASSERT_NEXT(a_stage_holds, s1_valid_ff && rsp_valid_ff && !rsp_chan.ready, s1_valid_ff, "item lost while result stalled")
   // A finishing result never also asks for a bus byte or carries read data.
   `ASSERT_SAME(a_done_alone, rsp_valid_ff && rsp_data_ff.done_res, !rsp_data_ff.tx_valid && !rsp_data_ff.rd_valid, "done result mixed with traffic")
   // Bytes sent with chip select high are idle bytes.
   `ASSERT_SAME(a_idle_byte, rsp_valid_ff && rsp_data_ff.tx_valid && !rsp_data_ff.cs_low, rsp_data_ff.tx_byte == 8'hFF, "non-idle byte with chip select high")

endmodule
`default_nettype wire

// File: rtl/core/sdspi_engine.sv
// Sequencer state and the single-step update that maps one item to one result.
`default_nettype none
module sdspi_engine #(
   parameter int BLOCK_BYTES     = sdspi_pkg::BLOCK_BYTES_DEF,
   parameter int INIT_IDLE_BYTES = sdspi_pkg::INIT_IDLE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire sdspi_pkg::req_type item,
   input  wire sdspi_pkg::cfg_type cfg,
   output      sdspi_pkg::rsp_type result
);
   import sdspi_pkg::*;

   localparam int BcW = $clog2(BLOCK_BYTES + 1);
   localparam logic [BcW-1:0] BC_BLOCK = BcW'(BLOCK_BYTES);
   localparam logic [BcW-1:0] BC_IDLE  = BcW'(INIT_IDLE_BYTES);
   localparam logic [31:0]    BLK32    = 32'(BLOCK_BYTES);

   phase_type      phase_ff, phase_in;
   logic [BcW-1:0] bc_ff, bc_in;
   logic [7:0]     retry_ff, retry_in;
   logic [7:0]     acmd_ff, acmd_in;
   logic           second_ff, second_in;
   logic           reinit_ff, reinit_in;
   logic [1:0]     kind_ff, kind_in;
   logic [31:0]    addr_ff, addr_in;
   logic           by_sector_ff, by_sector_in;
   logic [7:0]     first_ff, first_in;

   // One step of the sequencer: state update, then the byte to send next.
   always_comb begin
      logic       handled;
      logic       fin;
      logic [2:0] st;
      logic       ie;
      logic [2:0] ie_st;
      logic [BcW-1:0] rlen;
      logic [BcW-1:0] bc1;
      logic [2:0] bi;
      phase_in     = phase_ff;
      bc_in        = bc_ff;
      retry_in     = retry_ff;
      acmd_in      = acmd_ff;
      second_in    = second_ff;
      reinit_in    = reinit_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      by_sector_in = by_sector_ff;
      first_in     = first_ff;
      result       = '0;
      handled      = 1'b0;
      fin          = 1'b0;
      st           = ST_OK;
      ie           = 1'b0;
      ie_st        = ST_OK;
      bc1          = bc_ff + BcW'(1);
      rlen         = BcW'(6);
      bi           = 3'd0;

      if (item.opcode <= OP_WRITE && phase_ff == P_IDLE) begin
         // New request.
         handled   = 1'b1;
         kind_in   = item.opcode[1:0];
         reinit_in = 1'b0;
         if (item.opcode == OP_INIT) begin
            second_in = 1'b0;
            acmd_in   = 8'd0;
            phase_in  = P_INIT_IDLE;
            bc_in     = '0;
         end else begin
            addr_in  = by_sector_ff ? item.sector : item.sector * BLK32;
            retry_in = at_least_one(cfg.response_retries);
            phase_in = P_CMDRW;
            bc_in    = '0;
         end
      end else if (item.opcode == OP_XCHG) begin
         handled = 1'b1;
         case (phase_ff)
            P_INIT_IDLE: begin
               bc_in = bc1;
               if (bc1 >= BC_IDLE) begin
                  phase_in = P_CMD0;
                  bc_in    = '0;
               end
            end
            P_CMD0, P_CMD8, P_CMD55, P_ACMD41, P_CMD58, P_CMDRW: begin
               bc_in = bc1;
               if (bc1 >= BcW'(7)) begin
                  phase_in = phase_type'(phase_ff + 5'd1);
                  bc_in    = '0;
               end
            end
            P_CMD0_R, P_CMD8_R, P_CMD55_R, P_ACMD41_R, P_CMD58_R, P_CMDRW_R: begin
               if (bc_ff == '0) first_in = item.rx_byte;
               if (phase_ff == P_CMD58_R && bc_ff == BcW'(1) && first_ff == 8'd0)
                  by_sector_in = item.rx_byte[6];
               bc_in = bc1;
               case (phase_ff)
                  P_CMD0_R:  rlen = BcW'(1);
                  P_CMD58_R: rlen = BcW'(5);
                  P_CMDRW_R: rlen = (kind_ff == OP_READ[1:0]) ? BcW'(1) : BcW'(4);
                  default:   rlen = BcW'(6);
               endcase
               if (bc1 >= rlen) begin
                  // Judge the first response byte.
                  case (phase_ff)
                     P_CMD0_R: begin
                        if (first_in == R1_IDLE) begin
                           phase_in = P_CMD8;
                           bc_in    = '0;
                        end else if (!second_ff) begin
                           second_in = 1'b1;
                           phase_in  = P_INIT_IDLE;
                           bc_in     = '0;
                        end else begin
                           ie    = 1'b1;
                           ie_st = ST_NO_IDLE;
                        end
                     end
                     P_CMD8_R: begin
                        if (first_in != R1_IDLE) begin
                           ie    = 1'b1;
                           ie_st = ST_VOLTAGE;
                        end else begin
                           acmd_in  = 8'd0;
                           phase_in = P_CMD55;
                           bc_in    = '0;
                        end
                     end
                     P_CMD55_R: begin
                        if (first_in != R1_IDLE) begin
                           ie    = 1'b1;
                           ie_st = ST_ACMD41;
                        end else begin
                           phase_in = P_ACMD41;
                           bc_in    = '0;
                        end
                     end
                     P_ACMD41_R: begin
                        if (first_in == R1_READY) begin
                           phase_in = P_CMD58;
                           bc_in    = '0;
                        end else begin
                           acmd_in = acmd_ff + 8'd1;
                           if (acmd_in >= at_least_one(cfg.acmd41_tries)) begin
                              ie    = 1'b1;
                              ie_st = ST_ACMD41;
                           end else begin
                              phase_in = P_CMD55;
                              bc_in    = '0;
                           end
                        end
                     end
                     P_CMD58_R: begin
                        ie    = 1'b1;
                        ie_st = (first_in == R1_READY) ? ST_OK : ST_OCR;
                     end
                     default: begin
                        if (first_in == R1_READY) begin
                           phase_in = (kind_ff == OP_READ[1:0]) ? P_TOKEN : P_WTOKEN;
                           bc_in    = '0;
                        end else begin
                           retry_in = retry_ff - 8'd1;
                           if (retry_in == 8'd0) begin
                              fin = 1'b1;
                              st  = ST_TIMEOUT;
                           end else if (retry_in == cfg.reinit_at) begin
                              reinit_in = 1'b1;
                              second_in = 1'b0;
                              acmd_in   = 8'd0;
                              phase_in  = P_INIT_IDLE;
                              bc_in     = '0;
                           end else begin
                              phase_in = P_CMDRW;
                              bc_in    = '0;
                           end
                        end
                     end
                  endcase
                  // End of an init: resume the pending command after a good re-init.
                  if (ie) begin
                     if (reinit_ff && ie_st == ST_OK) begin
                        reinit_in = 1'b0;
                        phase_in  = P_CMDRW;
                        bc_in     = '0;
                     end else begin
                        if (reinit_ff) reinit_in = 1'b0;
                        fin = 1'b1;
                        st  = ie_st;
                     end
                  end
               end
            end
            P_TOKEN: begin
               if (item.rx_byte == TOKEN_START) begin
                  phase_in = P_RDATA;
                  bc_in    = '0;
               end else begin
                  bc_in = bc1;
                  if (bc1 >= BcW'(at_least_one(cfg.token_tries))) begin
                     fin = 1'b1;
                     st  = ST_NO_TOKEN;
                  end
               end
            end
            P_RDATA: begin
               result.rd_valid = 1'b1;
               result.rd_byte  = item.rx_byte;
               bc_in           = bc1;
               if (bc1 >= BC_BLOCK) begin
                  result.rd_last = 1'b1;
                  phase_in       = P_RCRC;
                  bc_in          = '0;
               end
            end
            P_RCRC: begin
               bc_in = bc1;
               if (bc1 >= BcW'(2)) begin
                  fin = 1'b1;
                  st  = ST_OK;
               end
            end
            P_WTOKEN: begin
               phase_in = P_WWAIT;
               bc_in    = '0;
            end
            P_WDATA: begin
               bc_in = bc1;
               if (bc1 >= BC_BLOCK) begin
                  phase_in = P_WCRC;
                  bc_in    = '0;
               end else begin
                  phase_in = P_WWAIT;
               end
            end
            P_WCRC: begin
               bc_in = bc1;
               if (bc1 >= BcW'(2)) begin
                  phase_in = P_WRESP;
                  bc_in    = '0;
               end
            end
            P_WRESP: begin
               if (bc_ff == '0) first_in = item.rx_byte;
               bc_in = bc1;
               if (bc1 >= BcW'(2)) begin
                  fin = 1'b1;
                  st  = (first_in[4:0] == WRESP_MASKED) ? ST_OK : ST_WR_REJ;
               end
            end
            default: handled = 1'b0;
         endcase
      end else if (item.opcode == OP_WDATA && phase_ff == P_WWAIT) begin
         // Pass one write data byte straight to the bus.
         phase_in        = P_WDATA;
         result.tx_valid = 1'b1;
         result.tx_byte  = item.wr_byte;
         result.cs_low   = 1'b1;
      end

      if (fin) begin
         phase_in        = P_IDLE;
         bc_in           = '0;
         result.done_res = 1'b1;
         result.status   = st;
      end else if (handled) begin
         // Byte to exchange next, taken from the updated state.
         bi = bc_in[2:0];
         case (phase_in)
            P_IDLE, P_WDATA: ;
            P_WWAIT: result.need_data = 1'b1;
            P_INIT_IDLE: begin
               result.tx_valid = 1'b1;
               result.tx_byte  = 8'hFF;
            end
            P_CMD0, P_CMD8, P_CMD55, P_ACMD41, P_CMD58: begin
               result.tx_valid = 1'b1;
               result.tx_byte  = init_cmd_byte(phase_in, bi);
               result.cs_low   = 1'b1;
            end
            P_CMDRW: begin
               result.tx_valid = 1'b1;
               result.cs_low   = 1'b1;
               case (bi)
                  3'd0: result.tx_byte = (kind_in == OP_READ[1:0]) ? CMD17_INDEX
                                                                     : CMD24_INDEX;
                  3'd1: result.tx_byte = addr_in[31:24];
                  3'd2: result.tx_byte = addr_in[23:16];
                  3'd3: result.tx_byte = addr_in[15:8];
                  3'd4: result.tx_byte = addr_in[7:0];
                  3'd5: result.tx_byte = 8'h00;
                  default: result.tx_byte = 8'hFF;
               endcase
            end
            P_WTOKEN: begin
               result.tx_valid = 1'b1;
               result.tx_byte  = TOKEN_START;
               result.cs_low   = 1'b1;
            end
            default: begin
               result.tx_valid = 1'b1;
               result.tx_byte  = 8'hFF;
               result.cs_low   = 1'b1;
            end
         endcase
      end
      result.high_capacity = by_sector_in;
   end

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         bc_ff        <= '0;
         retry_ff     <= '0;
         acmd_ff      <= '0;
         second_ff    <= 1'b0;
         reinit_ff    <= 1'b0;
         kind_ff      <= '0;
         addr_ff      <= '0;
         by_sector_ff <= 1'b0;
         first_ff     <= 8'hFF;
      end else if (step) begin
         phase_ff     <= phase_in;
         bc_ff        <= bc_in;
         retry_ff     <= retry_in;
         acmd_ff      <= acmd_in;
         second_ff    <= second_in;
         reinit_ff    <= reinit_in;
         kind_ff      <= kind_in;
         addr_ff      <= addr_in;
         by_sector_ff <= by_sector_in;
         first_ff     <= first_in;
      end
   end

endmodule
`default_nettype wire

// File: tb/tb_sd_card_spi_command_sequencer_unit.sv
// Testbench for the SD card SPI command sequencer: card-like stimulus, predictor and checker.
`default_nettype none
module tb_sd_card_spi_command_sequencer_unit;
   import sdspi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int DRAIN_CYCLES = 6;

   // Fixed init command bytes: index, four argument bytes, CRC, trailer.
   localparam logic [7:0] INIT_CMD_BYTES [0:4][0:6] = '{
      '{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h95, 8'hFF},
      '{8'h48, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h87, 8'hFF},
      '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
      '{8'h69, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
      '{8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h75, 8'hFF}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdspi_req_if req_bus();
   sdspi_rsp_if rsp_bus();
   sdspi_csr_if csr_bus();

   sd_card_spi_command_sequencer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .csr_chan (csr_bus.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted sequencer state and register copies.
   cfg_type     cfg_copy;
   phase_type   pc;
   logic [15:0] bcnt;
   logic [7:0]  retry_left;
   logic [7:0]  acmd_passes;
   logic        cmd0_retried;
   logic        reinit_active;
   logic [1:0]  req_kind;
   logic [31:0] card_addr;
   logic        sector_mode;
   logic [7:0]  r1_byte;
   rsp_type     step_out;

   rsp_type card_rsp_q[$];
   int mismatch_count = 0;
   int cycle_count = 0;

   // Handshake pacing.
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // Card behavior knobs for the stimulus.
   int good_pct = 100;
   phase_type fail_at = P_IDLE;
   int counted_items = 0;

   function automatic logic [7:0] nonzero(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic void go_phase(input phase_type p);
      pc = p;
      bcnt = 16'd0;
   endfunction

   function automatic void begin_init();
      cmd0_retried = 1'b0;
      acmd_passes = 8'd0;
      go_phase(P_INIT_IDLE);
   endfunction

   // Next byte to clock out for the current phase.
   function automatic void emit_byte();
      logic [7:0] b;
      logic cs;
      logic [2:0] i;
      b = 8'hFF;
      cs = 1'b1;
      i = bcnt[2:0];
      if (pc == P_IDLE || pc == P_WDATA) return;
      if (pc == P_WWAIT) begin
         step_out.need_data = 1'b1;
         return;
      end
      if (pc == P_INIT_IDLE) begin
         cs = 1'b0;
      end else if (pc inside {P_CMD0, P_CMD8, P_CMD55, P_ACMD41, P_CMD58}) begin
         b = INIT_CMD_BYTES[(int'(pc) - int'(P_CMD0)) / 2][(i < 3'd7) ? i : 3'd6];
      end else if (pc == P_CMDRW) begin
         if (i == 3'd0) b = (req_kind == 2'd1) ? CMD17_INDEX : CMD24_INDEX;
         else if (i <= 3'd4) b = 8'(card_addr >> (8 * (4 - i)));
         else if (i == 3'd5) b = 8'h00;
      end else if (pc == P_WTOKEN) begin
         b = TOKEN_START;
      end
      step_out.tx_valid = 1'b1;
      step_out.tx_byte = b;
      step_out.cs_low = cs;
   endfunction

   function automatic void end_request(input logic [2:0] st);
      go_phase(P_IDLE);
      step_out.done_res = 1'b1;
      step_out.status = st;
   endfunction

   function automatic void end_init(input logic [2:0] st);
      if (reinit_active) begin
         reinit_active = 1'b0;
         if (st == ST_OK) begin
            go_phase(P_CMDRW);
            emit_byte();
            return;
         end
      end
      end_request(st);
   endfunction

   function automatic int response_length();
      case (pc)
         P_CMD0_R:  return 1;
         P_CMD58_R: return 5;
         P_CMDRW_R: return (req_kind == 2'd1) ? 1 : 4;
         default:   return 6;
      endcase
   endfunction

   // Decide on a complete command response.
   function automatic void judge_response();
      case (pc)
         P_CMD0_R: begin
            if (r1_byte == R1_IDLE) go_phase(P_CMD8);
            else if (!cmd0_retried) begin
               cmd0_retried = 1'b1;
               go_phase(P_INIT_IDLE);
            end else begin
               end_init(ST_NO_IDLE);
               return;
            end
         end
         P_CMD8_R: begin
            if (r1_byte != R1_IDLE) begin
               end_init(ST_VOLTAGE);
               return;
            end
            acmd_passes = 8'd0;
            go_phase(P_CMD55);
         end
         P_CMD55_R: begin
            if (r1_byte != R1_IDLE) begin
               end_init(ST_ACMD41);
               return;
            end
            go_phase(P_ACMD41);
         end
         P_ACMD41_R: begin
            if (r1_byte == R1_READY) go_phase(P_CMD58);
            else begin
               acmd_passes++;
               if (acmd_passes >= nonzero(cfg_copy.acmd41_tries)) begin
                  end_init(ST_ACMD41);
                  return;
               end
               go_phase(P_CMD55);
            end
         end
         P_CMD58_R: begin
            end_init((r1_byte == R1_READY) ? ST_OK : ST_OCR);
            return;
         end
         default: begin
            if (r1_byte == R1_READY) go_phase((req_kind == 2'd1) ? P_TOKEN : P_WTOKEN);
            else begin
               retry_left--;
               if (retry_left == 8'd0) begin
                  end_request(ST_TIMEOUT);
                  return;
               end
               if (retry_left == cfg_copy.reinit_at) begin
                  reinit_active = 1'b1;
                  begin_init();
               end else go_phase(P_CMDRW);
            end
         end
      endcase
      emit_byte();
   endfunction

   // One byte came back from the card.
   function automatic void byte_exchanged(input logic [7:0] rx);
      case (pc)
         P_INIT_IDLE: begin
            bcnt++;
            if (bcnt >= INIT_IDLE_BYTES_DEF) go_phase(P_CMD0);
         end
         P_CMD0, P_CMD8, P_CMD55, P_ACMD41, P_CMD58, P_CMDRW: begin
            bcnt++;
            if (bcnt >= 7) go_phase(phase_type'(pc + 1));
         end
         P_CMD0_R, P_CMD8_R, P_CMD55_R, P_ACMD41_R, P_CMD58_R, P_CMDRW_R: begin
            if (bcnt == 0) r1_byte = rx;
            if (pc == P_CMD58_R && bcnt == 1 && r1_byte == 8'd0) sector_mode = rx[6];
            bcnt++;
            if (bcnt >= response_length()) begin
               judge_response();
               return;
            end
         end
         P_TOKEN: begin
            if (rx == TOKEN_START) go_phase(P_RDATA);
            else begin
               bcnt++;
               if (bcnt >= nonzero(cfg_copy.token_tries)) begin
                  end_request(ST_NO_TOKEN);
                  return;
               end
            end
         end
         P_RDATA: begin
            step_out.rd_valid = 1'b1;
            step_out.rd_byte = rx;
            bcnt++;
            if (bcnt >= BLOCK_BYTES_DEF) begin
               step_out.rd_last = 1'b1;
               go_phase(P_RCRC);
            end
         end
         P_RCRC: begin
            bcnt++;
            if (bcnt >= 2) begin
               end_request(ST_OK);
               return;
            end
         end
         P_WTOKEN: go_phase(P_WWAIT);
         P_WDATA: begin
            bcnt++;
            if (bcnt >= BLOCK_BYTES_DEF) go_phase(P_WCRC);
            else pc = P_WWAIT;
         end
         P_WCRC: begin
            bcnt++;
            if (bcnt >= 2) go_phase(P_WRESP);
         end
         P_WRESP: begin
            if (bcnt == 0) r1_byte = rx;
            bcnt++;
            if (bcnt >= 2) begin
               end_request((r1_byte[4:0] == WRESP_MASKED) ? ST_OK : ST_WR_REJ);
               return;
            end
         end
         default: return;
      endcase
      emit_byte();
   endfunction

   // Expected result of one accepted item; updates the predicted state.
   function automatic rsp_type predict_card_step(input req_type r);
      step_out = '0;
      if (r.opcode inside {OP_INIT, OP_READ, OP_WRITE} && pc == P_IDLE) begin
         req_kind = r.opcode[1:0];
         reinit_active = 1'b0;
         if (r.opcode == OP_INIT) begin_init();
         else begin
            card_addr = sector_mode ? r.sector : 32'(r.sector * BLOCK_BYTES_DEF);
            retry_left = nonzero(cfg_copy.response_retries);
            go_phase(P_CMDRW);
         end
         emit_byte();
      end else if (r.opcode == OP_XCHG) begin
         byte_exchanged(r.rx_byte);
      end else if (r.opcode == OP_WDATA && pc == P_WWAIT) begin
         pc = P_WDATA;
         step_out.tx_valid = 1'b1;
         step_out.tx_byte = r.wr_byte;
         step_out.cs_low = 1'b1;
      end
      step_out.high_capacity = sector_mode;
      return step_out;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR t=%0t %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (card_rsp_q.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = card_rsp_q.pop_front();
            if (rsp_bus.tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", 32'(rsp_bus.tx_valid), 32'(want.tx_valid));
            if (rsp_bus.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 32'(rsp_bus.tx_byte), 32'(want.tx_byte));
            if (rsp_bus.cs_low !== want.cs_low)
               report_mismatch("cs_low", 32'(rsp_bus.cs_low), 32'(want.cs_low));
            if (rsp_bus.need_data !== want.need_data)
               report_mismatch("need_data", 32'(rsp_bus.need_data), 32'(want.need_data));
            if (rsp_bus.rd_valid !== want.rd_valid)
               report_mismatch("rd_valid", 32'(rsp_bus.rd_valid), 32'(want.rd_valid));
            if (rsp_bus.rd_byte !== want.rd_byte)
               report_mismatch("rd_byte", 32'(rsp_bus.rd_byte), 32'(want.rd_byte));
            if (rsp_bus.rd_last !== want.rd_last)
               report_mismatch("rd_last", 32'(rsp_bus.rd_last), 32'(want.rd_last));
            if (rsp_bus.done_res !== want.done_res)
               report_mismatch("done_res", 32'(rsp_bus.done_res), 32'(want.done_res));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            if (rsp_bus.high_capacity !== want.high_capacity)
               report_mismatch("high_capacity", 32'(rsp_bus.high_capacity),
                               32'(want.high_capacity));
         end
      end
   end

   // Receiver pacing, with long hold-off stretches counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one item and hold it until accepted; valid stays high afterwards.
   task automatic send_item(input logic [2:0] op, input logic [31:0] sec,
                            input logic [7:0] rx, input logic [7:0] wr);
      req_type r;
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      r = {op, sec, rx, wr};
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.sector <= sec;
      req_bus.rx_byte <= rx;
      req_bus.wr_byte <= wr;
      do @(posedge clock); while (!req_bus.ready);
      card_rsp_q.push_back(predict_card_step(r));
   endtask

   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (card_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, issued only while the block is idle.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_RESPONSE_RETRIES: cfg_copy.response_retries = value;
         REG_REINIT_AT:        cfg_copy.reinit_at = value;
         REG_TOKEN_TRIES:      cfg_copy.token_tries = value;
         default:              cfg_copy.acmd41_tries = value;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] rr, input logic [7:0] ra,
                             input logic [7:0] tt, input logic [7:0] at);
      wait_all_results();
      write_reg(REG_RESPONSE_RETRIES, rr);
      write_reg(REG_REINIT_AT, ra);
      write_reg(REG_TOKEN_TRIES, tt);
      write_reg(REG_ACMD41_TRIES, at);
   endtask

   // Card byte for the current phase: a well-formed answer or a wrong one.
   function automatic logic [7:0] card_answer();
      logic ok;
      ok = (pc != fail_at) && ($urandom_range(99) < good_pct);
      case (pc)
         P_CMD0_R, P_CMD8_R, P_CMD55_R:
            if (bcnt == 0) return ok ? R1_IDLE : (($urandom_range(1) != 0) ? 8'h00 : 8'h05);
         P_ACMD41_R, P_CMDRW_R:
            if (bcnt == 0) return ok ? R1_READY : R1_IDLE;
         P_CMD58_R: begin
            if (bcnt == 0) return ok ? R1_READY : R1_IDLE;
         end
         P_TOKEN: begin
            if (!ok) return 8'hFF;
            return ($urandom_range(2) == 0) ? TOKEN_START : 8'hFF;
         end
         P_WRESP:
            if (bcnt == 0) return ok ? {3'($urandom_range(7)), 5'h05} : 8'h0B;
         default: ;
      endcase
      return 8'($urandom);
   endfunction

   // An item the block must ignore in the current phase.
   task automatic send_ignored_item();
      logic [2:0] op;
      op = 3'($urandom_range(5, 7));
      if ($urandom_range(1) != 0) begin
         if (pc == P_WWAIT) op = OP_XCHG;
         else if (pc != P_IDLE)
            op = ($urandom_range(1) != 0) ? OP_WDATA : 3'($urandom_range(2));
      end
      send_item(op, $urandom, 8'($urandom), 8'($urandom));
   endtask

   // One request from start to its final status.
   task automatic run_request(input logic [2:0] op, input logic [31:0] sec);
      send_item(op, sec, 8'($urandom), 8'($urandom));
      counted_items++;
      while (pc != P_IDLE) begin
         if ($urandom_range(99) < 3) send_ignored_item();
         if (pc == P_WWAIT) send_item(OP_WDATA, $urandom, 8'($urandom), 8'($urandom));
         else send_item(OP_XCHG, $urandom, card_answer(), 8'($urandom));
         counted_items++;
      end
   endtask

   function automatic logic [31:0] pick_sector();
      case ($urandom_range(3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_init_outcomes();
      fail_at = P_CMD0_R;   run_request(OP_INIT, 0);
      fail_at = P_CMD8_R;   run_request(OP_INIT, 0);
      fail_at = P_CMD55_R;  run_request(OP_INIT, 0);
      fail_at = P_ACMD41_R; run_request(OP_INIT, 0);
      fail_at = P_CMD58_R;  run_request(OP_INIT, 0);
      fail_at = P_IDLE;     run_request(OP_INIT, 0);
   endtask

   task automatic test_transfers();
      // Read at the top sector; in byte addressing the address wraps.
      fail_at = P_IDLE;
      run_request(OP_READ, 32'hFFFF_FFFF);
      run_request(OP_INIT, 0);
      run_request(OP_WRITE, 32'h8000_0001);
      fail_at = P_WRESP;    run_request(OP_WRITE, 32'h0);
      fail_at = P_TOKEN;    run_request(OP_READ, 32'h1234_5678);
      // Retries run down through a re-init to the timeout.
      fail_at = P_CMDRW_R;  run_request(OP_READ, 32'h0000_0007);
      fail_at = P_IDLE;
      repeat (4) send_ignored_item();
   endtask

   task automatic test_backpressure();
      wait_all_results();
      hold_left = 120;
      fail_at = P_IDLE;
      good_pct = 100;
      run_request(OP_INIT, 0);
      // The sender pauses here until every result is in.
      wait_all_results();
   endtask

   task automatic test_random(input int items, input int gap, input int stall);
      int stop_at;
      send_gap_pct = gap;
      recv_stall_pct = stall;
      stop_at = counted_items + items;
      fail_at = P_IDLE;
      while (counted_items < stop_at) begin
         case ($urandom_range(2))
            0: good_pct = 60;
            1: good_pct = 85;
            default: good_pct = 97;
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3, 4: run_request(OP_INIT, 0);
            5, 6: run_request(OP_READ, pick_sector());
            7, 8: run_request(OP_WRITE, pick_sector());
            default: send_ignored_item();
         endcase
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_INIT;
      req_bus.sector = '0;
      req_bus.rx_byte = '0;
      req_bus.wr_byte = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_RESPONSE_RETRIES;
      csr_bus.data = '0;
      cfg_copy = '{response_retries: 8'd10, reinit_at: 8'd5, token_tries: 8'd100,
                   acmd41_tries: 8'd4};
      pc = P_IDLE;
      bcnt = '0;
      retry_left = '0;
      acmd_passes = '0;
      cmd0_retried = 1'b0;
      reinit_active = 1'b0;
      req_kind = '0;
      card_addr = '0;
      sector_mode = 1'b0;
      r1_byte = 8'hFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_init_outcomes();
      test_transfers();
      test_backpressure();
      set_config(8'd1, 8'd0, 8'd1, 8'd1);
      test_random(240, 24, 72);
      set_config(8'd255, 8'd255, 8'd255, 8'd255);
      test_random(240, 72, 24);
      set_config(8'd0, 8'($urandom_range(1, 8)), 8'd0, 8'd0);
      test_random(120, 0, 0);
      set_config(8'($urandom_range(2, 12)), 8'($urandom_range(1, 6)),
                 8'($urandom_range(2, 40)), 8'($urandom_range(2, 6)));
      test_random(120, 0, 0);
      wait_all_results();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_if.sv
rtl/core/sdspi_engine.sv
rtl/core/sd_card_spi_command_sequencer_unit.sv
tb/tb_sd_card_spi_command_sequencer_unit.sv
